@@ rtl/core/lfp_pkg.sv @@
`default_nettype none

package lfp_pkg;

    // command queue between front and back
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam int unsigned CH_W   = 18;
    localparam int unsigned PBL_W  = 11;
    localparam int unsigned PIDX_W = 10;
    localparam int unsigned HIDX_W = 5;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef enum logic [1:0] {
        PROTO_DDP    = 2'd0,
        PROTO_E131   = 2'd1,
        PROTO_ARTNET = 2'd2,
        PROTO_NONE   = 2'd3
    } proto_t;

    typedef enum logic [2:0] {
        REG_DDP_PAYLOAD_MAX   = 3'd0,
        REG_DDP_VERSION_FLAGS = 3'd1,
        REG_DDP_PUSH_FLAG     = 3'd2,
        REG_DDP_TYPE_RGB      = 3'd3,
        REG_DDP_TYPE_RGBW     = 3'd4,
        REG_DDP_DEST_ID       = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        HDR_NONE = 2'd0,
        HDR_DDP  = 2'd1,
        HDR_ART  = 2'd2
    } hdr_kind_t;

    localparam logic [HIDX_W-1:0] DDP_HDR_LEN = 5'd10;
    localparam logic [HIDX_W-1:0] ART_HDR_LEN = 5'd18;
    localparam int unsigned       ART_ID_LEN  = 12;

    localparam logic [PBL_W-1:0] DDP_CAP_MIN  = 11'd12;
    localparam logic [PBL_W-1:0] DDP_CAP_MAX  = 11'd1440;
    localparam logic [PBL_W-1:0] ART_CAP_RGB  = 11'd510;
    localparam logic [PBL_W-1:0] ART_CAP_RGBW = 11'd512;
    localparam logic [7:0]       DDP_SEQ_MAX  = 8'd15;

    localparam logic [10:0] RST_PAYLOAD_MAX = 11'd1440;
    localparam logic [7:0]  RST_VER_FLAGS   = 8'd64;
    localparam logic [7:0]  RST_PUSH_FLAG   = 8'd1;
    localparam logic [7:0]  RST_TYPE_RGB    = 8'd11;
    localparam logic [7:0]  RST_TYPE_RGBW   = 8'd27;
    localparam logic [7:0]  RST_DEST_ID     = 8'd1;

    localparam logic [7:0] ART_ID [ART_ID_LEN] = '{
        8'h41, 8'h72, 8'h74, 8'h2d, 8'h4e, 8'h65,
        8'h74, 8'h00, 8'h00, 8'h50, 8'h00, 8'h0e
    };

    // one classified item: an error result, or a data byte with an optional header
    typedef struct packed {
        logic             is_err;
        hdr_kind_t        hdr;
        logic [7:0]       flags;
        logic [7:0]       seq;
        logic [7:0]       dtype;
        logic [7:0]       dest_id;
        logic [CH_W-1:0]  offset;
        logic [PBL_W-1:0] size;
        logic [7:0]       pidx;
        logic [7:0]       data;
        logic [7:0]       bri;
        logic             pend;
        logic             fend;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/lfp_front.sv @@
`default_nettype none

module lfp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [2:0]       cfg_index,
    input  wire logic [10:0]      cfg_data,
    input  wire logic             push,
    input  wire logic             kind,
    input  wire logic [1:0]       protocol,
    input  wire logic [15:0]      pixel_count,
    input  wire logic [7:0]       brightness,
    input  wire logic             rgbw,
    input  wire logic [7:0]       channel_byte,
    input  wire logic             q_full,
    output logic                  q_push,
    output lfp_pkg::cmd_t         q_cmd
);

    logic [10:0] payload_max_reg;
    logic [7:0]  ver_flags_reg;
    logic [7:0]  push_flag_reg;
    logic [7:0]  type_rgb_reg;
    logic [7:0]  type_rgbw_reg;
    logic [7:0]  dest_id_reg;

    logic [7:0]                  seq_reg, seq_next;
    logic                        active_reg, active_next;
    lfp_pkg::proto_t             proto_reg, proto_next;
    logic                        rgbw_reg, rgbw_next;
    logic [7:0]                  bri_reg, bri_next;
    logic [lfp_pkg::CH_W-1:0]    cl_reg, cl_next;
    logic [lfp_pkg::PBL_W-1:0]   pbl_reg, pbl_next;
    logic [lfp_pkg::CH_W-1:0]    off_reg, off_next;
    logic [lfp_pkg::PIDX_W-1:0]  pidx_reg, pidx_next;

    logic                        accept;
    logic [lfp_pkg::PBL_W-1:0]   cap_ddp, cap, size, pbl_eff, pbl_dec;
    logic                        is_last, need_hdr;
    logic [7:0]                  seq_ddp;
    logic [lfp_pkg::CH_W-1:0]    cl_dec, pc_ext, cl_start;
    lfp_pkg::proto_t             proto_in;

    assign accept   = push && !q_full;
    assign proto_in = lfp_pkg::proto_t'(protocol);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_max_reg <= lfp_pkg::RST_PAYLOAD_MAX;
            ver_flags_reg   <= lfp_pkg::RST_VER_FLAGS;
            push_flag_reg   <= lfp_pkg::RST_PUSH_FLAG;
            type_rgb_reg    <= lfp_pkg::RST_TYPE_RGB;
            type_rgbw_reg   <= lfp_pkg::RST_TYPE_RGBW;
            dest_id_reg     <= lfp_pkg::RST_DEST_ID;
        end
        else if (cfg_wr_en)
        begin
            case (lfp_pkg::cfg_reg_t'(cfg_index))
                lfp_pkg::REG_DDP_PAYLOAD_MAX:   payload_max_reg <= cfg_data;
                lfp_pkg::REG_DDP_VERSION_FLAGS: ver_flags_reg   <= cfg_data[7:0];
                lfp_pkg::REG_DDP_PUSH_FLAG:     push_flag_reg   <= cfg_data[7:0];
                lfp_pkg::REG_DDP_TYPE_RGB:      type_rgb_reg    <= cfg_data[7:0];
                lfp_pkg::REG_DDP_TYPE_RGBW:     type_rgbw_reg   <= cfg_data[7:0];
                lfp_pkg::REG_DDP_DEST_ID:       dest_id_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (payload_max_reg < lfp_pkg::DDP_CAP_MIN)
            cap_ddp = lfp_pkg::DDP_CAP_MIN;
        else if (payload_max_reg > lfp_pkg::DDP_CAP_MAX)
            cap_ddp = lfp_pkg::DDP_CAP_MAX;
        else
            cap_ddp = payload_max_reg;

        if (proto_reg == lfp_pkg::PROTO_DDP)
            cap = cap_ddp;
        else
            cap = rgbw_reg ? lfp_pkg::ART_CAP_RGBW : lfp_pkg::ART_CAP_RGB;

        is_last  = cl_reg <= lfp_pkg::CH_W'(cap);
        size     = is_last ? cl_reg[lfp_pkg::PBL_W-1:0] : cap;
        need_hdr = pbl_reg == '0;
        seq_ddp  = (seq_reg > lfp_pkg::DDP_SEQ_MAX) ? 8'd0 : seq_reg;
        pbl_eff  = need_hdr ? size : pbl_reg;
        pbl_dec  = pbl_eff - 1'b1;
        cl_dec   = cl_reg - 1'b1;
        pc_ext   = lfp_pkg::CH_W'(pixel_count);
        cl_start = rgbw ? (pc_ext << 2) : ((pc_ext << 1) + pc_ext);
    end

    always_comb
    begin
        seq_next    = seq_reg;
        active_next = active_reg;
        proto_next  = proto_reg;
        rgbw_next   = rgbw_reg;
        bri_next    = bri_reg;
        cl_next     = cl_reg;
        pbl_next    = pbl_reg;
        off_next    = off_reg;
        pidx_next   = pidx_reg;
        q_push      = 1'b0;
        q_cmd       = '0;

        if (accept && kind == lfp_pkg::KIND_START)
        begin
            // abandon any open frame
            active_next = 1'b0;
            pbl_next    = '0;
            off_next    = '0;
            pidx_next   = '0;
            cl_next     = '0;
            proto_next  = proto_in;
            bri_next    = brightness;
            rgbw_next   = rgbw;
            if (pixel_count == '0)
            begin
                q_push       = 1'b1;
                q_cmd.is_err = 1'b1;
            end
            else
            begin
                cl_next = cl_start;
                if (proto_in == lfp_pkg::PROTO_DDP || proto_in == lfp_pkg::PROTO_ARTNET)
                    active_next = 1'b1;
                if (proto_in == lfp_pkg::PROTO_ARTNET)
                    seq_next = seq_reg + 8'd1;
            end
        end
        else if (accept && active_reg && cl_reg != '0)
        begin
            q_push        = 1'b1;
            q_cmd.hdr     = lfp_pkg::HDR_NONE;
            q_cmd.flags   = ver_flags_reg | (is_last ? push_flag_reg : 8'd0);
            q_cmd.dtype   = rgbw_reg ? type_rgbw_reg : type_rgb_reg;
            q_cmd.dest_id = dest_id_reg;
            q_cmd.offset  = off_reg;
            q_cmd.size    = size;
            q_cmd.pidx    = pidx_reg[7:0];
            q_cmd.seq     = seq_reg;
            q_cmd.data    = channel_byte;
            q_cmd.bri     = bri_reg;
            if (need_hdr)
            begin
                if (proto_reg == lfp_pkg::PROTO_DDP)
                begin
                    q_cmd.hdr = lfp_pkg::HDR_DDP;
                    q_cmd.seq = {4'd0, seq_ddp[3:0]};
                    seq_next  = seq_ddp + 8'd1;
                end
                else
                    q_cmd.hdr = lfp_pkg::HDR_ART;
            end
            cl_next  = cl_dec;
            pbl_next = pbl_dec;
            off_next = off_reg + 1'b1;
            if (pbl_dec == '0)
            begin
                q_cmd.pend = 1'b1;
                pidx_next  = pidx_reg + 1'b1;
                if (cl_dec == '0)
                begin
                    q_cmd.fend  = 1'b1;
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= '0;
            active_reg <= 1'b0;
            proto_reg  <= lfp_pkg::PROTO_DDP;
            rgbw_reg   <= 1'b0;
            bri_reg    <= '0;
            cl_reg     <= '0;
            pbl_reg    <= '0;
            off_reg    <= '0;
            pidx_reg   <= '0;
        end
        else
        begin
            seq_reg    <= seq_next;
            active_reg <= active_next;
            proto_reg  <= proto_next;
            rgbw_reg   <= rgbw_next;
            bri_reg    <= bri_next;
            cl_reg     <= cl_next;
            pbl_reg    <= pbl_next;
            off_reg    <= off_next;
            pidx_reg   <= pidx_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lfp_cmd_fifo.sv @@
`default_nettype none

module lfp_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire lfp_pkg::cmd_t wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output lfp_pkg::cmd_t      rd_data,
    output logic               empty
);

    lfp_pkg::cmd_t                mem_reg [lfp_pkg::QDEPTH];
    logic [lfp_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lfp_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lfp_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_wr, do_rd;

    assign full    = count_reg == lfp_pkg::QCNT_W'(lfp_pkg::QDEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == lfp_pkg::QPTR_W'(lfp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == lfp_pkg::QPTR_W'(lfp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lfp_pkg::QCNT_W'(lfp_pkg::QDEPTH))
        else $error("command queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("command pushed into full queue");

endmodule

`default_nettype wire

@@ rtl/core/lfp_back.sv @@
`default_nettype none

module lfp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire lfp_pkg::cmd_t q_cmd,
    output logic               q_pop,
    input  wire logic          pop,
    output logic               empty,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               packet_end,
    output logic               frame_end,
    output logic               error
);

    logic                        out_valid_reg, out_valid_next;
    logic [lfp_pkg::HIDX_W-1:0]  hidx_reg, hidx_next;
    logic [7:0]                  byte_reg, byte_next;
    logic                        last_reg, last_next;
    logic                        pend_reg, pend_next;
    logic                        fend_reg, fend_next;
    logic                        err_reg, err_next;

    logic                        advance, take, in_hdr;
    logic [lfp_pkg::HIDX_W-1:0]  hdr_len;
    logic [7:0]                  hdr_byte, ddp_byte, art_byte, scaled;
    logic [16:0]                 prod;

    assign advance = !out_valid_reg || pop;
    assign take    = advance && !q_empty;
    assign empty   = !out_valid_reg;

    assign out_byte   = byte_reg;
    assign last       = last_reg;
    assign packet_end = pend_reg;
    assign frame_end  = fend_reg;
    assign error      = err_reg;

    // scale: (b * (1 + bri)) >> 8
    assign prod   = {9'd0, q_cmd.data} * ({9'd0, q_cmd.bri} + 17'd1);
    assign scaled = prod[15:8];

    always_comb
    begin
        case (q_cmd.hdr)
            lfp_pkg::HDR_DDP: hdr_len = lfp_pkg::DDP_HDR_LEN;
            lfp_pkg::HDR_ART: hdr_len = lfp_pkg::ART_HDR_LEN;
            default:          hdr_len = '0;
        endcase
        in_hdr = hidx_reg < hdr_len;

        // header byte positions
        case (hidx_reg)
            5'd0:    ddp_byte = q_cmd.flags;
            5'd1:    ddp_byte = q_cmd.seq;
            5'd2:    ddp_byte = q_cmd.dtype;
            5'd3:    ddp_byte = q_cmd.dest_id;
            5'd5:    ddp_byte = {6'd0, q_cmd.offset[17:16]};
            5'd6:    ddp_byte = q_cmd.offset[15:8];
            5'd7:    ddp_byte = q_cmd.offset[7:0];
            5'd8:    ddp_byte = {5'd0, q_cmd.size[10:8]};
            5'd9:    ddp_byte = q_cmd.size[7:0];
            default: ddp_byte = 8'd0;
        endcase

        if (hidx_reg < lfp_pkg::HIDX_W'(lfp_pkg::ART_ID_LEN))
            art_byte = lfp_pkg::ART_ID[hidx_reg[3:0]];
        else
        begin
            case (hidx_reg)
                5'd12:   art_byte = q_cmd.seq;
                5'd14:   art_byte = q_cmd.pidx;
                5'd16:   art_byte = {5'd0, q_cmd.size[10:8]};
                5'd17:   art_byte = q_cmd.size[7:0];
                default: art_byte = 8'd0;
            endcase
        end

        hdr_byte = (q_cmd.hdr == lfp_pkg::HDR_DDP) ? ddp_byte : art_byte;
    end

    always_comb
    begin
        out_valid_next = advance ? !q_empty : out_valid_reg;
        hidx_next      = hidx_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        fend_next      = fend_reg;
        err_next       = err_reg;
        q_pop          = 1'b0;

        if (take)
        begin
            if (q_cmd.is_err)
            begin
                byte_next = 8'd0;
                last_next = 1'b1;
                pend_next = 1'b0;
                fend_next = 1'b0;
                err_next  = 1'b1;
                q_pop     = 1'b1;
            end
            else if (in_hdr)
            begin
                byte_next = hdr_byte;
                last_next = 1'b0;
                pend_next = 1'b0;
                fend_next = 1'b0;
                err_next  = 1'b0;
                hidx_next = hidx_reg + 1'b1;
            end
            else
            begin
                byte_next = scaled;
                last_next = 1'b1;
                pend_next = q_cmd.pend;
                fend_next = q_cmd.fend;
                err_next  = 1'b0;
                hidx_next = '0;
                q_pop     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hidx_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            hidx_reg      <= hidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        pend_reg <= pend_next;
        fend_reg <= fend_next;
        err_reg  <= err_next;
    end

    a_closing_flags_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (err_reg || pend_reg) |-> last_reg)
        else $error("error or packet end on a header byte");

    a_frame_end_in_packet_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fend_reg |-> pend_reg)
        else $error("frame end without packet end");

    // the index sits one past the header while the data byte is pending
    a_hidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        hidx_reg <= lfp_pkg::ART_HDR_LEN)
        else $error("header index past longest header");

endmodule

`default_nettype wire

@@ rtl/core/led_frame_packetizer_core.sv @@
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------------
// input    | in        | push / full          | kind protocol pixel_count brightness
//          |           |                      | rgbw channel_byte
// result   | out       | empty / pop          | out_byte last packet_end frame_end error
// config   | in        | cfg_wr_en            | cfg_index cfg_data
//
// A data item without a header leaves as one result byte, one per cycle back to back
// while pop is held. A packet-opening item first emits its header in the back end,
// 10 bytes (DDP) or 18 bytes (Art-Net), one byte a cycle while pop is held, through
// the output register. A four-entry command queue lets the front keep taking items
// during a header burst; full rises once it fills. Start items produce no result
// unless pixel_count is zero. Reset clears frame state, the queue and the output valid
// flag, and loads the register defaults.
`default_nettype none

module led_frame_packetizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic        kind,
    input  wire logic [1:0]  protocol,
    input  wire logic [15:0] pixel_count,
    input  wire logic [7:0]  brightness,
    input  wire logic        rgbw,
    input  wire logic [7:0]  channel_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             packet_end,
    output logic             frame_end,
    output logic             error
);

    logic          q_push, q_full, q_pop, q_empty;
    lfp_pkg::cmd_t q_wr_cmd, q_rd_cmd;

    assign full = q_full;

    lfp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .kind         (kind),
        .protocol     (protocol),
        .pixel_count  (pixel_count),
        .brightness   (brightness),
        .rgbw         (rgbw),
        .channel_byte (channel_byte),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_wr_cmd)
    );

    lfp_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_cmd),
        .empty   (q_empty)
    );

    lfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_cmd      (q_rd_cmd),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .last       (last),
        .packet_end (packet_end),
        .frame_end  (frame_end),
        .error      (error)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int WATCHDOG_MAX  = 3000;

    typedef struct packed {
        logic             kind;
        lfp_pkg::proto_t  proto;
        logic [15:0]      pixels;
        logic [7:0]       bri;
        logic             four;
        logic [7:0]       chan;
    } feed_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       pend;
        logic       fend;
        logic       err;
    } pkt_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        kind = 1'b0;
    logic [1:0]  protocol = '0;
    logic [15:0] pixel_count = '0;
    logic [7:0]  brightness = '0;
    logic        rgbw = 1'b0;
    logic [7:0]  channel_byte = '0;
    logic        pop = 1'b0;
    wire         full;
    wire         empty;
    wire [7:0]   out_byte;
    wire         last;
    wire         packet_end;
    wire         frame_end;
    wire         error;

    led_frame_packetizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .protocol     (protocol),
        .pixel_count  (pixel_count),
        .brightness   (brightness),
        .rgbw         (rgbw),
        .channel_byte (channel_byte),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .last         (last),
        .packet_end   (packet_end),
        .frame_end    (frame_end),
        .error        (error)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    feed_item_t feed_q [$];
    pkt_byte_t  packet_bytes_q [$];

    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req = 1'b0;
    int mismatches = 0;

    // register copies
    logic [10:0] payload_max = lfp_pkg::RST_PAYLOAD_MAX;
    logic [7:0]  ver_flags = lfp_pkg::RST_VER_FLAGS;
    logic [7:0]  push_bits = lfp_pkg::RST_PUSH_FLAG;
    logic [7:0]  type_rgb = lfp_pkg::RST_TYPE_RGB;
    logic [7:0]  type_rgbw = lfp_pkg::RST_TYPE_RGBW;
    logic [7:0]  dest_id = lfp_pkg::RST_DEST_ID;

    // frame state
    logic [7:0]      seq_num = '0;
    logic            fr_active = 1'b0;
    lfp_pkg::proto_t fr_proto = lfp_pkg::PROTO_DDP;
    logic            fr_rgbw = 1'b0;
    logic [7:0]      fr_bri = '0;
    logic [17:0]     chans_left = '0;
    logic [10:0]     pkt_left = '0;
    logic [17:0]     chan_off = '0;
    logic [9:0]      pkt_idx = '0;

    task automatic predict_packet_bytes(input feed_item_t it);
        logic [7:0]  hdr [$];
        logic [10:0] cap;
        logic [10:0] size;
        logic        closing;
        logic [31:0] off32;
        logic [15:0] scaled;
        logic        pend;
        logic        fend;
        if (it.kind == lfp_pkg::KIND_START)
        begin
            fr_active = 1'b0;
            pkt_left = '0;
            chan_off = '0;
            pkt_idx = '0;
            chans_left = '0;
            fr_proto = it.proto;
            fr_bri = it.bri;
            fr_rgbw = it.four;
            if (it.pixels == 16'd0)
            begin
                packet_bytes_q.push_back({8'd0, 1'b1, 1'b0, 1'b0, 1'b1});
            end
            else
            begin
                chans_left = it.pixels * (it.four ? 18'd4 : 18'd3);
                if (it.proto == lfp_pkg::PROTO_DDP || it.proto == lfp_pkg::PROTO_ARTNET)
                    fr_active = 1'b1;
                if (it.proto == lfp_pkg::PROTO_ARTNET)
                    seq_num = seq_num + 8'd1;
            end
        end
        else if (fr_active && chans_left != 0)
        begin
            if (pkt_left == 0)
            begin
                if (fr_proto == lfp_pkg::PROTO_DDP)
                begin
                    cap = payload_max;
                    if (cap < lfp_pkg::DDP_CAP_MIN)
                        cap = lfp_pkg::DDP_CAP_MIN;
                    if (cap > lfp_pkg::DDP_CAP_MAX)
                        cap = lfp_pkg::DDP_CAP_MAX;
                end
                else
                begin
                    cap = fr_rgbw ? lfp_pkg::ART_CAP_RGBW : lfp_pkg::ART_CAP_RGB;
                end
                closing = (chans_left <= {7'd0, cap});
                size = closing ? chans_left[10:0] : cap;
                if (fr_proto == lfp_pkg::PROTO_DDP)
                begin
                    hdr.push_back(ver_flags | (closing ? push_bits : 8'd0));
                    // the shared sequence restarts once Art-Net has pushed it past 4 bits
                    if (seq_num > lfp_pkg::DDP_SEQ_MAX)
                        seq_num = '0;
                    hdr.push_back({4'd0, seq_num[3:0]});
                    seq_num = seq_num + 8'd1;
                    hdr.push_back(fr_rgbw ? type_rgbw : type_rgb);
                    hdr.push_back(dest_id);
                    off32 = {14'd0, chan_off};
                    hdr.push_back(off32[31:24]);
                    hdr.push_back(off32[23:16]);
                    hdr.push_back(off32[15:8]);
                    hdr.push_back(off32[7:0]);
                end
                else
                begin
                    for (int k = 0; k < lfp_pkg::ART_ID_LEN; k++)
                        hdr.push_back(lfp_pkg::ART_ID[k]);
                    hdr.push_back(seq_num);
                    hdr.push_back(8'd0);
                    hdr.push_back(pkt_idx[7:0]);
                    hdr.push_back(8'd0);
                end
                hdr.push_back({5'd0, size[10:8]});
                hdr.push_back(size[7:0]);
                pkt_left = size;
            end
            scaled = it.chan * (16'd1 + fr_bri);
            chans_left = chans_left - 18'd1;
            pkt_left = pkt_left - 11'd1;
            chan_off = chan_off + 18'd1;
            pend = 1'b0;
            fend = 1'b0;
            if (pkt_left == 0)
            begin
                pend = 1'b1;
                pkt_idx = pkt_idx + 10'd1;
                if (chans_left == 0)
                begin
                    fend = 1'b1;
                    fr_active = 1'b0;
                end
            end
            foreach (hdr[k])
                packet_bytes_q.push_back({hdr[k], 4'b0000});
            packet_bytes_q.push_back({scaled[15:8], 1'b1, pend, fend, 1'b0});
        end
    endtask

    // sender: offer the head of feed_q, hold it until the transfer happens
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                predict_packet_bytes(feed_q.pop_front());
            if (!push || !full)
            begin
                if (feed_q.size() != 0 && $urandom_range(99) >= tx_gap_pct)
                begin
                    push <= 1'b1;
                    kind <= feed_q[0].kind;
                    protocol <= feed_q[0].proto;
                    pixel_count <= feed_q[0].pixels;
                    brightness <= feed_q[0].bri;
                    rgbw <= feed_q[0].four;
                    channel_byte <= feed_q[0].chan;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    int  rx_hold_left = 0;
    bit  rx_hold_done = 1'b0;

    // receiver: compare every result transfer with the oldest expected byte
    always @(posedge clk)
    begin
        pkt_byte_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (packet_bytes_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: byte %h last %b pend %b fend %b err %b",
                                 out_byte, last, packet_end, frame_end, error);
                end
                else
                begin
                    want = packet_bytes_q.pop_front();
                    if (out_byte !== want.value || last !== want.last ||
                        packet_end !== want.pend || frame_end !== want.fend ||
                        error !== want.err)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: got %h/%b/%b/%b/%b expected %h/%b/%b/%b/%b",
                                     out_byte, last, packet_end, frame_end, error,
                                     want.value, want.last, want.pend, want.fend, want.err);
                    end
                end
            end
            if (rx_hold_req && !rx_hold_done)
            begin
                rx_hold_left = LONG_HOLD;
                rx_hold_done = 1'b1;
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic void queue_start(input lfp_pkg::proto_t pr, input logic [15:0] pc,
                                        input logic [7:0] lvl, input logic four);
        feed_q.push_back({lfp_pkg::KIND_START, pr, pc, lvl, four, 8'($urandom_range(255))});
    endfunction

    function automatic void queue_data(input logic [7:0] b);
        feed_q.push_back({lfp_pkg::KIND_DATA, lfp_pkg::proto_t'($urandom_range(3)),
                          16'($urandom), 8'($urandom_range(255)),
                          1'($urandom_range(1)), b});
    endfunction

    task automatic queue_random_frames(input int n_items);
        int              made;
        int              pick;
        int              nd;
        int              nch;
        logic [15:0]     pc;
        logic            four;
        logic [7:0]      lvl;
        lfp_pkg::proto_t pr;
        made = 0;
        while (made < n_items)
        begin
            pick = $urandom_range(99);
            four = 1'($urandom_range(1));
            nd = $urandom_range(9);
            lvl = (nd == 0) ? 8'd0 : (nd == 1) ? 8'd255 : 8'($urandom_range(255));
            if (pick < 8)
            begin
                queue_start(lfp_pkg::proto_t'($urandom_range(3)), 16'd0, lvl, four);
                made++;
            end
            else if (pick < 16)
            begin
                pr = (pick < 12) ? lfp_pkg::PROTO_E131 : lfp_pkg::PROTO_NONE;
                queue_start(pr, 16'($urandom_range(1, 65535)), lvl, four);
                made++;
                repeat ($urandom_range(3))
                    queue_data(8'($urandom_range(255)));
            end
            else
            begin
                pr = (pick < 62) ? lfp_pkg::PROTO_DDP : lfp_pkg::PROTO_ARTNET;
                if ($urandom_range(9) == 0)
                    pc = 16'($urandom_range(1, 65535));
                else if ($urandom_range(3) == 0)
                    pc = 16'($urandom_range(1, 16));
                else
                    pc = 16'($urandom_range(1, 6));
                nch = pc * (four ? 4 : 3);
                // cut huge frames and a few small ones short: the next start abandons them
                if (nch > 64)
                    nd = $urandom_range(1, 40);
                else if ($urandom_range(9) == 0)
                    nd = $urandom_range(1, nch);
                else
                    nd = nch;
                queue_start(pr, pc, lvl, four);
                repeat (nd)
                    queue_data(8'($urandom_range(255)));
                made += 1 + nd;
                if ($urandom_range(9) == 0)
                    queue_data(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (feed_q.size() != 0 || push || packet_bytes_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input lfp_pkg::cfg_reg_t idx, input logic [10:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            lfp_pkg::REG_DDP_PAYLOAD_MAX:   payload_max = val;
            lfp_pkg::REG_DDP_VERSION_FLAGS: ver_flags = val[7:0];
            lfp_pkg::REG_DDP_PUSH_FLAG:     push_bits = val[7:0];
            lfp_pkg::REG_DDP_TYPE_RGB:      type_rgb = val[7:0];
            lfp_pkg::REG_DDP_TYPE_RGBW:     type_rgbw = val[7:0];
            lfp_pkg::REG_DDP_DEST_ID:       dest_id = val[7:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_regs(input logic [10:0] pmax, input logic [7:0] fl,
                                  input logic [7:0] pb, input logic [7:0] t3,
                                  input logic [7:0] t4, input logic [7:0] id);
        write_reg(lfp_pkg::REG_DDP_PAYLOAD_MAX, pmax);
        write_reg(lfp_pkg::REG_DDP_VERSION_FLAGS, {3'd0, fl});
        write_reg(lfp_pkg::REG_DDP_PUSH_FLAG, {3'd0, pb});
        write_reg(lfp_pkg::REG_DDP_TYPE_RGB, {3'd0, t3});
        write_reg(lfp_pkg::REG_DDP_TYPE_RGBW, {3'd0, t4});
        write_reg(lfp_pkg::REG_DDP_DEST_ID, {3'd0, id});
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset register values
        queue_data(8'hFF);
        queue_start(lfp_pkg::PROTO_DDP, 16'd0, 8'd0, 1'b0);
        queue_start(lfp_pkg::PROTO_ARTNET, 16'd0, 8'd255, 1'b1);
        queue_start(lfp_pkg::PROTO_E131, 16'd2, 8'd255, 1'b0);
        queue_data(8'h55);
        queue_data(8'hAA);
        queue_start(lfp_pkg::PROTO_NONE, 16'd1, 8'd9, 1'b1);
        queue_data(8'h01);
        queue_start(lfp_pkg::PROTO_DDP, 16'd1, 8'd255, 1'b0);
        queue_data(8'hFF);
        queue_data(8'h00);
        queue_data(8'h80);
        queue_data(8'h7F);
        queue_start(lfp_pkg::PROTO_DDP, 16'd1, 8'd0, 1'b1);
        queue_data(8'hFF);
        queue_data(8'h01);
        queue_data(8'h02);
        queue_data(8'h03);
        queue_start(lfp_pkg::PROTO_ARTNET, 16'd1, 8'd127, 1'b1);
        queue_data(8'hFF);
        queue_data(8'hFE);
        queue_data(8'h80);
        queue_data(8'h40);
        queue_start(lfp_pkg::PROTO_ARTNET, 16'd2, 8'd200, 1'b0);
        queue_data(8'h0A);
        queue_data(8'h14);
        queue_start(lfp_pkg::PROTO_DDP, 16'hFFFF, 8'd255, 1'b1);
        queue_data(8'hFF);
        queue_data(8'h00);
        queue_start(lfp_pkg::PROTO_ARTNET, 16'd1, 8'd1, 1'b0);
        queue_data(8'hFF);
        queue_data(8'h03);
        queue_data(8'h07);
        wait_drained();

        // smallest payload, no idling, one long receiver hold-off
        write_all_regs(11'd12, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
        tx_gap_pct = 0;
        rx_stall_pct = 0;
        queue_random_frames(50);
        rx_hold_req = 1'b1;
        wait_drained();
        queue_random_frames(40);
        wait_drained();

        // payload below the floor, sender idles
        write_all_regs(11'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
        tx_gap_pct = 47;
        rx_stall_pct = 0;
        queue_random_frames(45);
        wait_drained();
        queue_random_frames(45);
        wait_drained();

        // odd payload size, receiver stalls
        write_all_regs(11'($urandom_range(13, 47)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)));
        tx_gap_pct = 0;
        rx_stall_pct = 47;
        queue_random_frames(45);
        wait_drained();
        queue_random_frames(45);
        wait_drained();

        // payload above the ceiling, both sides idle, push the sequence past 4 bits
        write_all_regs(11'd2047, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        tx_gap_pct = 14;
        rx_stall_pct = 14;
        queue_random_frames(45);
        wait_drained();
        repeat (20)
            queue_start(lfp_pkg::PROTO_ARTNET, 16'($urandom_range(1, 65535)), 8'd0, 1'b0);
        queue_start(lfp_pkg::PROTO_ARTNET, 16'd1, 8'd255, 1'b1);
        repeat (4)
            queue_data(8'($urandom_range(255)));
        queue_start(lfp_pkg::PROTO_DDP, 16'd1, 8'd255, 1'b0);
        repeat (3)
            queue_data(8'($urandom_range(255)));
        queue_random_frames(40);
        wait_drained();

        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lfp_pkg.sv
rtl/core/lfp_front.sv
rtl/core/lfp_cmd_fifo.sv
rtl/core/lfp_back.sv
rtl/core/led_frame_packetizer_core.sv
dv/testbench.sv
